@@ design/cti_pkg.sv @@
// ============================================================================
// cti_pkg: shared definitions for the calibration table interpolator
// Item types, sizing constants, codes and the table address helper.
// ============================================================================
package cti_pkg;

    // sizing
    localparam int MOTOR_COUNT = 4;
    localparam int MAX_ENTRIES = 32;
    localparam int ADC_BITS    = 10;
    localparam int CHANNELS    = 2;

    // fixed field widths
    localparam int ENTRY_W    = 16;
    localparam int READING_W  = 10;
    localparam int Q_W        = 24;
    localparam int ENTRIES_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // derived
    localparam int TABLE_DEPTH = CHANNELS * MOTOR_COUNT * MAX_ENTRIES;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int K_W         = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int RD_W        = (ADC_BITS < READING_W) ? ADC_BITS : READING_W;
    localparam int PROD_W      = RD_W + Q_W;
    localparam int DIV_CNT_W   = $clog2(PROD_W + 1);
    localparam int SUM_W       = Q_W + K_W + 2;

    // command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // region codes
    localparam logic [1:0] REGION_BELOW  = 2'd0;
    localparam logic [1:0] REGION_INTERP = 2'd1;
    localparam logic [1:0] REGION_ABOVE  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_LAST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_ENTRIES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_FIRST    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_STEP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_LAST     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_ENTRIES  = 3'd7;

    // reset values and limits
    localparam logic signed [Q_W-1:0]   STEP_RST    = 24'sd256;
    localparam logic [ENTRIES_W-1:0]    ENTRIES_RST = 6'd32;
    localparam logic signed [Q_W-1:0]   Q_MAX       = 24'sh7FFFFF;
    localparam logic signed [Q_W-1:0]   Q_MIN       = 24'sh800000;

    typedef struct packed {
        logic                 cmd;
        logic                 channel;
        logic [1:0]           motor;
        logic [4:0]           entry_index;
        logic [ENTRY_W-1:0]   entry_value;
        logic [READING_W-1:0] reading;
    } t_in_item;

    typedef struct packed {
        logic signed [Q_W-1:0] value;
        logic [1:0]            region;
        logic                  out_channel;
        logic [1:0]            out_motor;
    } t_out_item;

    // first table address of one channel/motor table
    function automatic logic [ADDR_W-1:0] base_addr(input logic channel,
                                                    input logic [1:0] motor);
        int a;
        a = (int'(channel) * MOTOR_COUNT + int'(motor)) * MAX_ENTRIES;
        return ADDR_W'(a);
    endfunction

endpackage

@@ design/cti_table_ram.sv @@
// ============================================================================
// cti_table_ram: calibration table storage
// One write port, one read port, registered read data. No reset contents.
// ============================================================================
module cti_table_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [cti_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [cti_pkg::ENTRY_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [cti_pkg::ADDR_W-1:0]  i_raddr,
    output logic [cti_pkg::ENTRY_W-1:0] o_rdata
);

    logic [cti_pkg::ENTRY_W-1:0] r_mem [cti_pkg::TABLE_DEPTH];
    logic [cti_pkg::ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/cti_div.sv @@
// ============================================================================
// cti_div: serial unsigned divider
// Restoring division, one quotient bit per cycle, PROD_W-bit quotient.
// ============================================================================
module cti_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cti_pkg::PROD_W-1:0]  i_dividend,
    input  logic [cti_pkg::ENTRY_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [cti_pkg::PROD_W-1:0]  o_quotient
);

    logic                          r_active;
    logic [cti_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [cti_pkg::PROD_W-1:0]    r_dvd;
    logic [cti_pkg::ENTRY_W:0]     r_rem;
    logic [cti_pkg::ENTRY_W:0]     rem_sh;
    logic                          ge;

    assign rem_sh = {r_rem[cti_pkg::ENTRY_W-1:0], r_dvd[cti_pkg::PROD_W-1]};
    assign ge     = rem_sh >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_cnt    <= cti_pkg::DIV_CNT_W'(cti_pkg::PROD_W);
        end else if (r_active) begin
            r_cnt <= r_cnt - cti_pkg::DIV_CNT_W'(1);
            if (r_cnt == cti_pkg::DIV_CNT_W'(1)) begin
                r_active <= 1'b0;
            end
        end
    end

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_active) begin
            r_dvd <= {r_dvd[cti_pkg::PROD_W-2:0], ge};
            r_rem <= ge ? (rem_sh - {1'b0, i_divisor}) : rem_sh;
        end
    end

    assign o_done     = r_active && (r_cnt == cti_pkg::DIV_CNT_W'(1));
    assign o_quotient = r_dvd;

endmodule

@@ design/calibration_table_interpolator_unit.sv @@
// ============================================================================
// calibration_table_interpolator_unit: raw ADC reading to volts or amps
// Per channel/motor tables of ascending raw values; a convert finds the first
// entry above the reading and interpolates inside that segment (signed Q.8).
// ============================================================================
//
//  channel   signals                         handshake
//  -------   ------------------------------  ---------------------------------
//  item in   start, busy, i_item             taken when start && !busy
//  result    o_strobe, o_result              one cycle, cannot be held off
//  config    i_cfg_we, i_cfg_idx, i_cfg_data written on every cycle with we
//
//  Load item: written into the table on the accept edge; busy stays low.
//  Convert with motor out of range: result in the next cycle.
//  Convert: the table is read one entry per cycle, the compare following the
//  read in the next cycle; a below or above result ends the scan. An
//  interpolated result then passes through the multiply, the serial divider,
//  the sum and the saturating output, in that order.
//  Reset (synchronous, active low) idles the sequencer and restores the
//  config registers; the table is not cleared. Results are never stalled.
//
module calibration_table_interpolator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  cti_pkg::t_in_item              i_item,
    output logic                           o_strobe,
    output cti_pkg::t_out_item             o_result,
    input  logic                           i_cfg_we,
    input  logic [cti_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cti_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DWAIT  = 3'd4;
    localparam logic [2:0] S_SUM    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    // ---------------------------------------------------------------- config
    logic signed [cti_pkg::Q_W-1:0]     r_first   [cti_pkg::CHANNELS];
    logic signed [cti_pkg::Q_W-1:0]     r_step    [cti_pkg::CHANNELS];
    logic signed [cti_pkg::Q_W-1:0]     r_last    [cti_pkg::CHANNELS];
    logic [cti_pkg::ENTRIES_W-1:0]      r_entries [cti_pkg::CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < cti_pkg::CHANNELS; c++) begin
                r_first[c]   <= '0;
                r_step[c]    <= cti_pkg::STEP_RST;
                r_last[c]    <= '0;
                r_entries[c] <= cti_pkg::ENTRIES_RST;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cti_pkg::REG_VOLT_FIRST:   r_first[0]   <= i_cfg_data;
                cti_pkg::REG_VOLT_STEP:    r_step[0]    <= i_cfg_data;
                cti_pkg::REG_VOLT_LAST:    r_last[0]    <= i_cfg_data;
                cti_pkg::REG_VOLT_ENTRIES: r_entries[0] <= i_cfg_data[cti_pkg::ENTRIES_W-1:0];
                cti_pkg::REG_AMP_FIRST:    r_first[1]   <= i_cfg_data;
                cti_pkg::REG_AMP_STEP:     r_step[1]    <= i_cfg_data;
                cti_pkg::REG_AMP_LAST:     r_last[1]    <= i_cfg_data;
                cti_pkg::REG_AMP_ENTRIES:  r_entries[1] <= i_cfg_data[cti_pkg::ENTRIES_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------- registers
    logic [2:0]                          r_state, n_state;
    logic                                r_channel;
    logic [1:0]                          r_motor;
    logic [cti_pkg::RD_W-1:0]            r_reading;
    logic [cti_pkg::ADDR_W-1:0]          r_base;
    logic [cti_pkg::CNT_W-1:0]           r_n;      // entries in use, clamped
    logic [cti_pkg::CNT_W-1:0]           r_k;      // next entry to read
    logic [cti_pkg::CNT_W-1:0]           r_rdk;    // entry in the read register
    logic                                r_rdv;    // read data is a table entry
    logic                                r_rdend;  // read slot was past the end
    logic [cti_pkg::ENTRY_W-1:0]         r_hi, r_lo;
    logic signed [cti_pkg::SUM_W-1:0]    r_seg;    // first + (k-1)*step
    logic [cti_pkg::PROD_W-1:0]          r_prod;
    logic [cti_pkg::ENTRY_W-1:0]         r_den;
    logic                                r_neg;
    logic signed [cti_pkg::SUM_W-1:0]    r_sum;
    logic                                r_strobe;
    cti_pkg::t_out_item                  r_out;

    // --------------------------------------------------------- accept decode
    logic                                acc, acc_load, acc_conv;
    logic                                motor_ok, idx_ok;
    logic [cti_pkg::ENTRIES_W-1:0]       e_sel;
    logic [cti_pkg::CNT_W-1:0]           n_cnt;

    assign busy     = (r_state != S_IDLE);
    assign acc      = start && !busy;
    assign acc_load = acc && (i_item.cmd == cti_pkg::CMD_LOAD);
    assign acc_conv = acc && (i_item.cmd == cti_pkg::CMD_CONVERT);
    assign motor_ok = 32'(i_item.motor) < cti_pkg::MOTOR_COUNT;
    assign idx_ok   = 32'(i_item.entry_index) < cti_pkg::MAX_ENTRIES;
    assign e_sel    = r_entries[i_item.channel];

    // zero entries acts as one, too many is clamped to the table size
    always_comb begin
        if (e_sel == '0) begin
            n_cnt = cti_pkg::CNT_W'(1);
        end else if (32'(e_sel) > cti_pkg::MAX_ENTRIES) begin
            n_cnt = cti_pkg::CNT_W'(cti_pkg::MAX_ENTRIES);
        end else begin
            n_cnt = cti_pkg::CNT_W'(e_sel);
        end
    end

    // ----------------------------------------------------------------- table
    logic                          ram_we, ram_re;
    logic [cti_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [cti_pkg::ENTRY_W-1:0]   ram_rdata;
    logic                          issue_ok;

    assign ram_we    = acc_load && motor_ok && idx_ok;
    assign ram_waddr = cti_pkg::base_addr(i_item.channel, i_item.motor)
                     + cti_pkg::ADDR_W'(i_item.entry_index);
    assign issue_ok  = r_k < r_n;
    assign ram_re    = (r_state == S_SCAN) && issue_ok;
    assign ram_raddr = r_base + cti_pkg::ADDR_W'(r_k);

    cti_table_ram u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_item.entry_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // -------------------------------------------------------------- datapath
    logic signed [cti_pkg::Q_W-1:0]  c_step;
    logic [cti_pkg::Q_W-1:0]         step_abs;
    logic [cti_pkg::RD_W-1:0]        diff;
    logic [cti_pkg::PROD_W-1:0]      prod_c;
    logic                            below;
    logic                            div_start, div_done;
    logic [cti_pkg::PROD_W-1:0]      div_q;
    logic signed [cti_pkg::Q_W:0]    q_mag, q_signed;
    logic signed [cti_pkg::Q_W-1:0]  sat_val;

    assign c_step   = r_step[r_channel];
    assign step_abs = c_step[cti_pkg::Q_W-1] ? (~c_step + 1'b1) : c_step;
    // lo <= reading here, so lo fits the reading width
    assign diff     = r_reading - r_lo[cti_pkg::RD_W-1:0];
    assign prod_c   = cti_pkg::PROD_W'(diff) * cti_pkg::PROD_W'(step_abs);
    assign below    = 16'(r_reading) < ram_rdata;

    assign div_start = (r_state == S_DSTART);

    cti_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // quotient magnitude stays below |step|, so Q_W bits hold it
    assign q_mag    = $signed({1'b0, div_q[cti_pkg::Q_W-1:0]});
    assign q_signed = r_neg ? -q_mag : q_mag;

    always_comb begin
        if (r_sum > cti_pkg::SUM_W'(cti_pkg::Q_MAX)) begin
            sat_val = cti_pkg::Q_MAX;
        end else if (r_sum < cti_pkg::SUM_W'(cti_pkg::Q_MIN)) begin
            sat_val = cti_pkg::Q_MIN;
        end else begin
            sat_val = r_sum[cti_pkg::Q_W-1:0];
        end
    end

    // ------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc_conv && motor_ok) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_rdend) begin
                    n_state = S_IDLE;
                end else if (r_rdv && below) begin
                    n_state = (r_rdk == '0) ? S_IDLE : S_MUL;
                end
            end
            S_MUL:    n_state = S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (div_done) n_state = S_SUM;
            end
            S_SUM:    n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------- result path
    logic                           emit;
    logic signed [cti_pkg::Q_W-1:0] emit_val;
    logic [1:0]                     emit_region;
    logic                           emit_ch;
    logic [1:0]                     emit_motor;

    always_comb begin
        emit        = 1'b0;
        emit_val    = r_first[r_channel];
        emit_region = cti_pkg::REGION_BELOW;
        emit_ch     = r_channel;
        emit_motor  = r_motor;
        if (acc_conv && !motor_ok) begin
            // no table for this motor: first value of the channel
            emit       = 1'b1;
            emit_val   = r_first[i_item.channel];
            emit_ch    = i_item.channel;
            emit_motor = i_item.motor;
        end else if (r_state == S_SCAN && r_rdend) begin
            emit        = 1'b1;
            emit_val    = r_last[r_channel];
            emit_region = cti_pkg::REGION_ABOVE;
        end else if (r_state == S_SCAN && r_rdv && below && r_rdk == '0) begin
            emit = 1'b1;
        end else if (r_state == S_OUT) begin
            emit        = 1'b1;
            emit_val    = sat_val;
            emit_region = cti_pkg::REGION_INTERP;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_rdv    <= 1'b0;
            r_rdend  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= emit;
            if (acc_conv) begin
                r_rdv   <= 1'b0;
                r_rdend <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_rdv   <= issue_ok;
                r_rdend <= !issue_ok;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (acc_conv) begin
            r_channel <= i_item.channel;
            r_motor   <= i_item.motor;
            r_reading <= i_item.reading[cti_pkg::RD_W-1:0];
            r_base    <= cti_pkg::base_addr(i_item.channel, i_item.motor);
            r_n       <= n_cnt;
            r_k       <= '0;
            r_seg     <= cti_pkg::SUM_W'(r_first[i_item.channel]);
        end
        if (r_state == S_SCAN) begin
            if (issue_ok) r_k <= r_k + cti_pkg::CNT_W'(1);
            r_rdk <= r_k;
            if (r_rdv && !r_rdend) begin
                r_hi <= ram_rdata;
                r_lo <= r_hi;
                // passed another segment boundary
                if (r_rdk != '0 && !below) begin
                    r_seg <= r_seg + cti_pkg::SUM_W'(c_step);
                end
            end
        end
        if (r_state == S_MUL) begin
            r_prod <= prod_c;
            r_den  <= r_hi - r_lo;
            r_neg  <= c_step[cti_pkg::Q_W-1];
        end
        if (r_state == S_SUM) begin
            r_sum <= r_seg + cti_pkg::SUM_W'(q_signed);
        end
        if (emit) begin
            r_out.value       <= emit_val;
            r_out.region      <= emit_region;
            r_out.out_channel <= emit_ch;
            r_out.out_motor   <= emit_motor;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

@@ design/cti_checker.sv @@
// ============================================================================
// cti_checker: port level checks for the interpolator
// Watches the item and result ports; attached to the top level by bind.
// ============================================================================
module cti_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input cti_pkg::t_in_item  i_item,
    input logic               o_strobe
);

    // a load never occupies the unit
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == cti_pkg::CMD_LOAD) |=> !busy)
        else $error("load item made the unit busy");

    // busy only follows an accepted convert
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && i_item.cmd == cti_pkg::CMD_CONVERT))
        else $error("busy rose without a convert item");

    // every result comes from a convert in progress or just accepted
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) || $past(start && i_item.cmd == cti_pkg::CMD_CONVERT)))
        else $error("result without a convert item");

    // a convert ends with its result
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_strobe)
        else $error("convert finished without a result");

endmodule

bind calibration_table_interpolator_unit cti_checker u_cti_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe)
);
